// File: hw/rtl/tscm_pkg.sv
// Shared types, constants and character mapping functions for the timestamp code codec.
package tscm_pkg;

	localparam int CODE_LEN = 8;
	localparam int TEXT_LEN = 9;
	localparam int TS_W     = 32;
	localparam int VAL_W    = 6;
	localparam int SUM_W    = 10;
	localparam int BYTE_W   = 8;

	// Special characters and the value ranges of the code alphabet.
	localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UY    = 8'h59;
	localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LZ    = 8'h7a;
	localparam logic [VAL_W-1:0]  VAL_DIGIT_BASE = 6'd26;
	localparam logic [VAL_W-1:0]  VAL_LOWER_BASE = 6'd35;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_e;

	typedef logic [CODE_LEN-1:0][BYTE_W-1:0] code_t;
	typedef logic [TEXT_LEN-1:0][BYTE_W-1:0] text_t;

	// Result of looking up one character in the code alphabet.
	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] val;
	} sym_val_t;

	// Registered input item.
	typedef struct packed {
		cmd_e            cmd;
		logic [TS_W-1:0] timestamp_in;
		text_t           text;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [TS_W-1:0] timestamp_out;
		logic            bad_format;
		code_t           code;
	} rsp_t;

	// Map a grid sum (0..60) to its code character.
	function automatic logic [BYTE_W-1:0] sym_of_value(input logic [VAL_W-1:0] v);
		logic [BYTE_W-1:0] v8;
		v8 = {2'b00, v};
		if (v == '0)
			return CHAR_ZERO;
		else if (v < VAL_DIGIT_BASE)
			return BYTE_W'(CHAR_UA + v8 - 8'd1);
		else if (v < VAL_LOWER_BASE)
			return BYTE_W'(CHAR_ONE + v8 - {2'b00, VAL_DIGIT_BASE});
		else
			return BYTE_W'(CHAR_LA + v8 - {2'b00, VAL_LOWER_BASE});
	endfunction

	// Map a character back to its value; ok is low outside the alphabet.
	function automatic sym_val_t value_of_sym(input logic [BYTE_W-1:0] c);
		sym_val_t r;
		r.ok  = 1'b1;
		r.val = '0;
		if (c >= CHAR_UA && c <= CHAR_UY)
			r.val = VAL_W'(c - CHAR_UA + 8'd1);
		else if (c == CHAR_ZERO)
			r.val = '0;
		else if (c >= CHAR_ONE && c <= CHAR_NINE)
			r.val = VAL_W'(c - CHAR_ONE + {2'b00, VAL_DIGIT_BASE});
		else if (c >= CHAR_LA && c <= CHAR_LZ)
			r.val = VAL_W'(c - CHAR_LA + {2'b00, VAL_LOWER_BASE});
		else
			r.ok = 1'b0;
		return r;
	endfunction

endpackage

// File: hw/rtl/tscm_if.sv
// Valid/ready channel interfaces for the request and response sides of the codec.
interface tscm_req_if;
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [31:0]           timestamp_in;
	logic [7:0]            text_0;
	logic [7:0]            text_1;
	logic [7:0]            text_2;
	logic [7:0]            text_3;
	logic [7:0]            text_4;
	logic [7:0]            text_5;
	logic [7:0]            text_6;
	logic [7:0]            text_7;
	logic [7:0]            text_8;

	modport source (
		output valid, cmd, timestamp_in, text_0, text_1, text_2, text_3, text_4,
		       text_5, text_6, text_7, text_8,
		input  ready
	);
	modport sink (
		input  valid, cmd, timestamp_in, text_0, text_1, text_2, text_3, text_4,
		       text_5, text_6, text_7, text_8,
		output ready
	);
endinterface

interface tscm_rsp_if;
	logic                  valid;
	logic                  ready;
	logic [31:0]           timestamp_out;
	logic                  bad_format;
	logic [7:0]            code_0;
	logic [7:0]            code_1;
	logic [7:0]            code_2;
	logic [7:0]            code_3;
	logic [7:0]            code_4;
	logic [7:0]            code_5;
	logic [7:0]            code_6;
	logic [7:0]            code_7;

	modport source (
		output valid, timestamp_out, bad_format, code_0, code_1, code_2, code_3,
		       code_4, code_5, code_6, code_7,
		input  ready
	);
	modport sink (
		input  valid, timestamp_out, bad_format, code_0, code_1, code_2, code_3,
		       code_4, code_5, code_6, code_7,
		output ready
	);
endinterface

// File: hw/rtl/tscm_enc.sv
// Encoder datapath: timestamp nibbles through the fixed matrix into code characters.
module tscm_enc (
	input  logic [tscm_pkg::TS_W-1:0] timestamp,
	output tscm_pkg::code_t           code
);
	import tscm_pkg::*;

	logic [3:0]       nib [CODE_LEN];
	logic [VAL_W-1:0] src [4][2];
	logic [VAL_W-1:0] dst [4][2];

	// Split into nibbles, most significant first; column-major into the grid.
	always_comb begin
		for (int i = 0; i < CODE_LEN; i++) begin
			nib[i] = timestamp[TS_W-1-4*i -: 4];
			src[i % 4][i / 4] = {2'b00, nib[i]};
		end
	end

	// Constant matrix product per column; every sum stays within 0..60.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			dst[0][c] = VAL_W'(src[0][c] + src[2][c]);
			dst[1][c] = VAL_W'(src[0][c] + src[1][c] + src[3][c]);
			dst[2][c] = src[2][c];
			dst[3][c] = VAL_W'(src[0][c] + src[1][c] + {src[3][c][VAL_W-2:0], 1'b0});
		end
	end

	// Read the grid row-major into characters.
	always_comb begin
		for (int k = 0; k < CODE_LEN; k++) begin
			code[k] = sym_of_value(dst[k / 2][k % 2]);
		end
	end

endmodule

// File: hw/rtl/tscm_dec.sv
// Decoder datapath: character validation, inverse matrix and nibble packing.
module tscm_dec (
	input  tscm_pkg::text_t           text,
	output logic [tscm_pkg::TS_W-1:0] timestamp,
	output logic                      bad_format
);
	import tscm_pkg::*;

	logic                    skip;
	logic [BYTE_W-1:0]       ch   [CODE_LEN];
	sym_val_t                sv   [CODE_LEN];
	logic signed [SUM_W-1:0] src  [4][2];
	logic signed [SUM_W-1:0] sum  [4][2];
	logic [BYTE_W-1:0]       wrap [4][2];
	logic [TS_W-1:0]         acc;
	logic                    all_ok;

	// Drop a leading '#' and look up each of the eight characters.
	always_comb begin
		skip   = (text[0] == CHAR_HASH);
		all_ok = 1'b1;
		for (int i = 0; i < CODE_LEN; i++) begin
			ch[i] = skip ? text[i+1] : text[i];
			sv[i] = value_of_sym(ch[i]);
			all_ok = all_ok & sv[i].ok;
			src[i / 2][i % 2] = $signed({{(SUM_W-VAL_W){1'b0}}, sv[i].val});
		end
	end

	// Inverse matrix per column, then wrap each sum to signed 8 bits.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			sum[0][c] = src[0][c] - src[2][c];
			sum[1][c] = (src[1][c] <<< 1) + src[2][c] - src[0][c] - src[3][c];
			sum[2][c] = src[2][c];
			sum[3][c] = src[3][c] - src[1][c];
			for (int r = 0; r < 4; r++) begin
				wrap[r][c] = sum[r][c][BYTE_W-1:0];
			end
		end
	end

	// Pack column-major: shift left a nibble and OR in the sign-extended byte.
	always_comb begin
		acc = '0;
		for (int i = 0; i < CODE_LEN; i++) begin
			acc = {acc[TS_W-5:0], 4'b0000} |
			      {{(TS_W-BYTE_W){wrap[i % 4][i / 4][BYTE_W-1]}}, wrap[i % 4][i / 4]};
		end
		bad_format = !all_ok;
		timestamp  = all_ok ? acc : '1;
	end

endmodule

// File: hw/rtl/timestamp_code_matrix_codec_top.sv
// Top level of the timestamp code codec: input register, datapaths, result register.
// An accepted transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless stalled; the input and result registers
// make a two-stage pipeline, so a request is taken while a result waits if stage 1 is free.
// Reset: arst_n clears both stage valid flags at once; the data registers are not reset.
module timestamp_code_matrix_codec_top (
	input  logic        clk,
	input  logic        arst_n,
	tscm_req_if.sink    req,
	tscm_rsp_if.source  rsp
);
	import tscm_pkg::*;

	logic            v_s1;
	logic            v_s2;
	logic            accept;
	logic            adv;
	req_t            req_s1;
	rsp_t            rsp_s2;
	rsp_t            rsp_next;
	code_t           enc_code;
	logic [TS_W-1:0] dec_ts;
	logic            dec_bad;

	// Handshake: stage 1 moves on when the result register is free or being drained.
	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign accept    = req.valid && req.ready;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				v_s2 <= 1'b1;
			else if (rsp.ready)
				v_s2 <= 1'b0;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.cmd          <= cmd_e'(req.cmd);
			req_s1.timestamp_in <= req.timestamp_in;
			req_s1.text         <= {req.text_8, req.text_7, req.text_6, req.text_5,
			                        req.text_4, req.text_3, req.text_2, req.text_1,
			                        req.text_0};
		end
	end

	tscm_enc u_enc (
		.timestamp (req_s1.timestamp_in),
		.code      (enc_code)
	);

	tscm_dec u_dec (
		.text       (req_s1.text),
		.timestamp  (dec_ts),
		.bad_format (dec_bad)
	);

	// Select the active direction; the other direction's fields read as zero.
	always_comb begin
		rsp_next = '0;
		unique case (req_s1.cmd)
			CMD_ENCODE: rsp_next.code = enc_code;
			CMD_DECODE: begin
				rsp_next.timestamp_out = dec_ts;
				rsp_next.bad_format    = dec_bad;
			end
			default: rsp_next = '0;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv)
			rsp_s2 <= rsp_next;
	end

	assign rsp.valid         = v_s2;
	assign rsp.timestamp_out = rsp_s2.timestamp_out;
	assign rsp.bad_format    = rsp_s2.bad_format;
	assign rsp.code_0        = rsp_s2.code[0];
	assign rsp.code_1        = rsp_s2.code[1];
	assign rsp.code_2        = rsp_s2.code[2];
	assign rsp.code_3        = rsp_s2.code[3];
	assign rsp.code_4        = rsp_s2.code[4];
	assign rsp.code_5        = rsp_s2.code[5];
	assign rsp.code_6        = rsp_s2.code[6];
	assign rsp.code_7        = rsp_s2.code[7];

	// A bad format always comes with an all-ones timestamp.
	a_bad_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_format |-> rsp.timestamp_out == '1)
		else $error("bad_format without all-ones timestamp");

	// A bad-format result never carries code characters.
	a_bad_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_format |-> rsp_s2.code == '0)
		else $error("bad_format with nonzero code");

	// An accepted transaction occupies stage 1 in the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted transaction lost");

	// Stage 1 advancing always leaves a valid result behind it.
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2)
		else $error("advanced transaction lost");

endmodule

// File: sim/tscm_codec_checker.sv
// Checker for the timestamp code codec: predicts every result and compares it on arrival.
module tscm_codec_checker (
	input  logic clk,
	input  logic arst_n,
	tscm_req_if  req,
	tscm_rsp_if  rsp,
	output int   errors,
	output int   pending
);
	import tscm_pkg::*;

	rsp_t expected_results[$];
	int   fail_count = 0;
	int   outstanding = 0;

	assign errors  = fail_count;
	assign pending = outstanding;

	// Turns a grid sum into its code character.
	function automatic logic [7:0] glyph_of(input int v);
		if (v < 1)
			return CHAR_ZERO;
		if (v < 26)
			return 8'(CHAR_UA + v - 1);
		if (v < 35)
			return 8'(CHAR_ONE + v - 26);
		return 8'(CHAR_LA + v - 35);
	endfunction

	// Turns a code character back into its value, or -1 outside the alphabet.
	function automatic int glyph_value(input logic [7:0] c);
		if (c >= CHAR_UA && c <= CHAR_UY)
			return int'(c) - int'(CHAR_UA) + 1;
		if (c == CHAR_ZERO)
			return 0;
		if (c >= CHAR_ONE && c <= CHAR_NINE)
			return int'(c) - int'(CHAR_ONE) + 26;
		if (c >= CHAR_LA && c <= CHAR_LZ)
			return int'(c) - int'(CHAR_LA) + 35;
		return -1;
	endfunction

	// Computes the result the codec owes for one request.
	function automatic rsp_t predict_codec(input req_t item);
		rsp_t         res;
		int           grid [4][2];
		int           prod [4][2];
		int           v;
		int           lead;
		logic [7:0]   wrapped;
		logic [31:0]  acc;
		res = '0;
		if (item.cmd == CMD_ENCODE) begin
			// Nibbles go down the columns, most significant first.
			for (int i = 0; i < 8; i++)
				grid[i % 4][i / 4] = int'(item.timestamp_in[31 - 4 * i -: 4]);
			for (int c = 0; c < 2; c++) begin
				prod[0][c] = grid[0][c] + grid[2][c];
				prod[1][c] = grid[0][c] + grid[1][c] + grid[3][c];
				prod[2][c] = grid[2][c];
				prod[3][c] = grid[0][c] + grid[1][c] + 2 * grid[3][c];
			end
			for (int k = 0; k < 8; k++)
				res.code[k] = glyph_of(prod[k / 2][k % 2]);
			return res;
		end
		// A leading hash shifts the eight characters up by one byte.
		lead = (item.text[0] == CHAR_HASH) ? 1 : 0;
		for (int k = 0; k < 8; k++) begin
			v = glyph_value(item.text[lead + k]);
			if (v < 0) begin
				res.timestamp_out = '1;
				res.bad_format    = 1'b1;
				return res;
			end
			grid[k / 2][k % 2] = v;
		end
		for (int c = 0; c < 2; c++) begin
			prod[0][c] = grid[0][c] - grid[2][c];
			prod[1][c] = -grid[0][c] + 2 * grid[1][c] + grid[2][c] - grid[3][c];
			prod[2][c] = grid[2][c];
			prod[3][c] = grid[3][c] - grid[1][c];
		end
		// Each sum wraps to a signed byte, then is sign-extended and ORed in.
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			wrapped = prod[i % 4][i / 4][7:0];
			acc     = (acc << 4) | {{24{wrapped[7]}}, wrapped};
		end
		res.timestamp_out = acc;
		return res;
	endfunction

	// Responses are checked before the request of the same edge is queued.
	always @(posedge clk) begin : watch
		rsp_t seen;
		rsp_t want;
		req_t taken;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				seen.timestamp_out = rsp.timestamp_out;
				seen.bad_format    = rsp.bad_format;
				seen.code          = {rsp.code_7, rsp.code_6, rsp.code_5, rsp.code_4,
				                      rsp.code_3, rsp.code_2, rsp.code_1, rsp.code_0};
				if (expected_results.size() == 0) begin
					$error("response transaction with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.timestamp_out !== seen.timestamp_out) begin
						$error("timestamp_out: expected %h, got %h",
						       want.timestamp_out, seen.timestamp_out);
						fail_count++;
					end
					if (want.bad_format !== seen.bad_format) begin
						$error("bad_format: expected %b, got %b",
						       want.bad_format, seen.bad_format);
						fail_count++;
					end
					for (int k = 0; k < 8; k++) begin
						if (want.code[k] !== seen.code[k]) begin
							$error("code_%0d: expected %h, got %h", k, want.code[k], seen.code[k]);
							fail_count++;
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				taken.cmd          = cmd_e'(req.cmd);
				taken.timestamp_in = req.timestamp_in;
				taken.text         = {req.text_8, req.text_7, req.text_6, req.text_5, req.text_4,
				                      req.text_3, req.text_2, req.text_1, req.text_0};
				expected_results.push_back(predict_codec(taken));
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// File: sim/tb_timestamp_code_matrix_codec_top.sv
// Testbench top for the timestamp code codec: stimulus, idling phases and the verdict.
module tb_timestamp_code_matrix_codec_top;
	import tscm_pkg::*;

	// Characters outside the alphabet that sit next to its ranges, plus 'Z', '[' and '#'.
	localparam logic [7:0][7:0] MISFITS = {CHAR_HASH, 8'h5a, 8'h40, 8'h5b,
	                                       8'h60, 8'h7b, 8'h2f, 8'h3a};

	logic  clk;
	logic  arst_n;
	int    errors;
	int    pending;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    idle_plan [4] = '{0, 60, 0, 9};
	int    stall_plan [4] = '{0, 0, 60, 9};
	string glyphs = "0ABCDEFGHIJKLMNOPQRSTUVWXY123456789abcdefghijklmnopqrstuvwxyz";

	tscm_req_if req_bus ();
	tscm_rsp_if rsp_bus ();

	timestamp_code_matrix_codec_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	tscm_codec_checker codec_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("tb_timestamp_code_matrix_codec_top: done, errors");
		$finish;
	end

	// The response side stalls at the rate of the current phase.
	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one request after a random gap and waits for its transaction.
	task automatic send_request(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.cmd          <= item.cmd;
		req_bus.timestamp_in <= item.timestamp_in;
		req_bus.text_0       <= item.text[0];
		req_bus.text_1       <= item.text[1];
		req_bus.text_2       <= item.text[2];
		req_bus.text_3       <= item.text[3];
		req_bus.text_4       <= item.text[4];
		req_bus.text_5       <= item.text[5];
		req_bus.text_6       <= item.text[6];
		req_bus.text_7       <= item.text[7];
		req_bus.text_8       <= item.text[8];
		do
			@(posedge clk);
		while (!req_bus.ready);
	endtask

	// Waits until every queued result has come back.
	task automatic drain_results();
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic req_t stamp_item(input logic [31:0] stamp);
		req_t item;
		item.cmd          = CMD_ENCODE;
		item.timestamp_in = stamp;
		for (int k = 0; k < 9; k++)
			item.text[k] = 8'($urandom_range(255));
		return item;
	endfunction

	function automatic req_t text_item(input string s);
		req_t item;
		item.cmd          = CMD_DECODE;
		item.timestamp_in = $urandom();
		item.text         = '0;
		for (int k = 0; k < s.len() && k < 9; k++)
			item.text[k] = s[k];
		return item;
	endfunction

	// Encodes of random timestamps and well-formed codes with random content; the rest is noise or broken codes.
	function automatic req_t random_item();
		req_t item;
		int   pick;
		int   lead;
		int   spot;
		item.cmd          = CMD_DECODE;
		item.timestamp_in = $urandom();
		for (int k = 0; k < 9; k++)
			item.text[k] = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 40) begin
			item.cmd = CMD_ENCODE;
			return item;
		end
		if (pick < 50)
			return item;
		lead = $urandom_range(1);
		if (lead == 1)
			item.text[0] = CHAR_HASH;
		for (int k = 0; k < 8; k++)
			item.text[lead + k] = glyphs[$urandom_range(60)];
		if (pick >= 85) begin
			spot = lead + $urandom_range(7);
			if ($urandom_range(1) == 1)
				item.text[spot] = 8'($urandom_range(255, 128));
			else
				item.text[spot] = MISFITS[$urandom_range(7)];
		end
		return item;
	endfunction

	initial begin : stimulus
		req_t        item;
		logic [31:0] stamps [8];
		stamps = '{32'h0000_0000, 32'hffff_ffff, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
		           32'h1234_5678, 32'h89ab_cdef, 32'h0000_0001, 32'h8000_0000};

		arst_n               = 1'b0;
		req_bus.valid        = 1'b0;
		req_bus.cmd          = CMD_ENCODE;
		req_bus.timestamp_in = '0;
		req_bus.text_0       = '0;
		req_bus.text_1       = '0;
		req_bus.text_2       = '0;
		req_bus.text_3       = '0;
		req_bus.text_4       = '0;
		req_bus.text_5       = '0;
		req_bus.text_6       = '0;
		req_bus.text_7       = '0;
		req_bus.text_8       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed encodes: extreme and patterned timestamps.
		for (int i = 0; i < 8; i++)
			send_request(stamp_item(stamps[i]));

		// Directed decodes: extremes, overflowing sums, the hash prefix and bad characters.
		send_request(text_item("00000000"));
		send_request(text_item("zzzzzzzz"));
		send_request(text_item("#zzzzzzzz"));
		send_request(text_item("AAAAAAAAZ"));
		send_request(text_item("#Y9a1zA0Y"));
		send_request(text_item("#0000#000"));
		send_request(text_item("#0000000Z"));
		for (int j = 0; j < 8; j++) begin
			item         = text_item("00000000");
			item.text[1] = MISFITS[j];
			send_request(item);
		end
		item         = text_item("00000000");
		item.text[3] = 8'h80;
		send_request(item);
		item         = text_item("00000000");
		item.text[7] = 8'hff;
		send_request(item);

		// Random phases, each closed by a pause until all results are back.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = idle_plan[phase];
			recv_stall_pct = stall_plan[phase];
			repeat (150)
				send_request(random_item());
			req_bus.valid <= 1'b0;
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb_timestamp_code_matrix_codec_top: done, clean");
		else
			$display("tb_timestamp_code_matrix_codec_top: done, errors");
		$finish;
	end

endmodule
